>>> hw/rtl/nnt_pkg.sv
// shared types and constants for the nearest-neighbor tour block
`timescale 1ns / 1ps
package nnt_pkg;
	localparam int MaxCities = 64;
	localparam int CoordBits = 15;
	localparam int IdxW = $clog2(MaxCities);
	localparam int CntW = $clog2(MaxCities + 1);
	localparam int SqW = 2 * CoordBits + 1;
	localparam int DistW = CoordBits + 1;
	localparam int LenW = 22;
	localparam int CityW = 16 + 2 * CoordBits;

	typedef enum logic [3:0] {
		ST_LOAD, ST_ROW, ST_RD, ST_WAIT, ST_DIST, ST_WR_J, ST_WR_I, ST_STEP, ST_LEN_RD,
		ST_LEN_WAIT, ST_LEN_DIST, ST_OUT_RD, ST_OUT_WAIT, ST_OUT
	} nnt_state_t;

	typedef struct packed {
		logic             wr_en;
		logic [IdxW-1:0]  wr_addr;
		logic             wr_sel_in;
		logic [IdxW-1:0]  rd_addr;
		logic             load_a;
		logic             load_b;
		logic             start_dist;
		logic             set_best;
		logic             acc_clear;
		logic             acc_add;
		logic             hold_b;
	} nnt_cmd_t;

	typedef struct packed {
		logic             dist_done;
		logic             closer;
	} nnt_sts_t;
endpackage

>>> hw/rtl/nnt_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module nnt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

>>> hw/rtl/nnt_isqrt.sv
// iterative integer square root, taking two radicand bits per step
`timescale 1ns / 1ps
module nnt_isqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [nnt_pkg::SqW-1:0] value,
	output logic                    done,
	output logic [nnt_pkg::DistW-1:0] root
);
	import nnt_pkg::*;
	localparam int Steps = (SqW + 1) / 2;
	localparam int StepW = $clog2(Steps + 1);
	localparam int ValW = 2 * Steps;
	localparam int RemW = SqW + 2;
	logic [RemW-1:0]  rem_q;
	logic [ValW-1:0]  val_q;
	logic [DistW-1:0] root_q;
	logic [StepW-1:0] cnt_q;
	logic             busy_q;
	logic [RemW-1:0]  rem_sh;
	logic [RemW-1:0]  trial;

	always_comb begin
		rem_sh = {rem_q[RemW-3:0], val_q[ValW-1 -: 2]};
		trial  = RemW'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= StepW'(Steps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			val_q  <= ValW'(value);
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[ValW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[DistW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[DistW-2:0], 1'b0};
			end
		end
	end
	assign root = root_q;
endmodule

>>> hw/rtl/nnt_datapath.sv
// city store, distance unit, best-distance and length registers
`timescale 1ns / 1ps
module nnt_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nnt_pkg::nnt_cmd_t         cmd,
	input  logic [nnt_pkg::CityW-1:0] in_city,
	output nnt_pkg::nnt_sts_t         sts,
	output logic [15:0]               out_id,
	output logic [nnt_pkg::LenW-1:0]  length
);
	import nnt_pkg::*;
	logic [CityW-1:0] rd_city;
	logic [CityW-1:0] wr_city;
	logic [CityW-1:0] a_q;
	logic [CityW-1:0] b_q;
	logic [CoordBits-1:0] dx;
	logic [CoordBits-1:0] dy;
	logic [SqW-1:0] dx_w;
	logic [SqW-1:0] dy_w;
	logic [SqW-1:0] sq_s1;
	logic [DistW-1:0] root;
	logic [DistW-1:0] best_q;
	logic [LenW-1:0] len_q;
	logic root_done;
	logic sq_go_s1;
	logic sq_go_s2;
	logic [CoordBits-1:0] ax, ay, bx, by;

	// swap writes take the old entry at i+1 straight from the read port and city j from b
	assign wr_city = cmd.wr_sel_in ? in_city : (cmd.hold_b ? b_q : rd_city);

	nnt_ram #(.Width(CityW), .Depth(MaxCities)) u_store (
		.clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_city),
		.rd_addr(cmd.rd_addr), .rd_data(rd_city)
	);

	assign ax = a_q[16 +: CoordBits];
	assign ay = a_q[16 + CoordBits +: CoordBits];
	assign bx = b_q[16 +: CoordBits];
	assign by = b_q[16 + CoordBits +: CoordBits];
	assign dx = (ax > bx) ? ax - bx : bx - ax;
	assign dy = (ay > by) ? ay - by : by - ay;
	assign dx_w = SqW'(dx);
	assign dy_w = SqW'(dy);

	always_ff @(posedge clk) begin
		if (cmd.load_a) a_q <= rd_city;
		if (cmd.load_b) b_q <= rd_city;
		sq_s1 <= dx_w * dx_w + dy_w * dy_w;
		if (root_done && cmd.set_best) best_q <= root;
		if (cmd.acc_clear) len_q <= '0;
		else if (root_done && cmd.acc_add) len_q <= len_q + LenW'(root);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_go_s1 <= 1'b0;
			sq_go_s2 <= 1'b0;
		end else begin
			sq_go_s1 <= cmd.start_dist;
			sq_go_s2 <= sq_go_s1;
		end
	end

	nnt_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go_s2), .value(sq_s1),
		.done(root_done), .root(root)
	);

	assign sts.dist_done = root_done;
	assign sts.closer = root < best_q;
	assign out_id = rd_city[15:0];
	assign length = len_q;
endmodule

>>> hw/rtl/nnt_ctrl.sv
// sequencer for loading, tour search, length sum and output
`timescale 1ns / 1ps
module nnt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_final,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 m_last,
	output logic                 m_ovf,
	output logic                 m_capture,
	output nnt_pkg::nnt_cmd_t    cmd,
	input  nnt_pkg::nnt_sts_t    sts
);
	import nnt_pkg::*;
	nnt_state_t state_q, state_d;
	logic [CntW-1:0] n_q, n_d;
	logic [CntW-1:0] i_q, i_d;
	logic [CntW-1:0] j_q, j_d;
	logic ovf_q, ovf_d;
	logic first_q, first_d;
	logic v_q, v_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD; n_q <= '0; i_q <= '0; j_q <= '0;
			ovf_q <= 1'b0; first_q <= 1'b0; v_q <= 1'b0;
		end else begin
			state_q <= state_d; n_q <= n_d; i_q <= i_d; j_q <= j_d;
			ovf_q <= ovf_d; first_q <= first_d; v_q <= v_d;
		end
	end

	assign m_tvalid = v_q;
	assign m_last = (i_q == n_q - 1'b1);
	assign m_ovf = ovf_q;

	always_comb begin
		state_d = state_q; n_d = n_q; i_d = i_q; j_d = j_q;
		ovf_d = ovf_q; first_d = first_q; v_d = v_q;
		cmd = '0; s_tready = 1'b0; m_capture = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				cmd.wr_sel_in = 1'b1;
				cmd.wr_addr = n_q[IdxW-1:0];
				if (s_tvalid) begin
					if (n_q < CntW'(MaxCities)) begin
						cmd.wr_en = 1'b1;
						n_d = n_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (s_final) begin
						i_d = '0;
						state_d = ST_ROW;
					end
				end
			end
			ST_ROW: begin
				if (i_q + 1'b1 < n_q) begin
					cmd.rd_addr = i_q[IdxW-1:0];
					j_d = i_q + 1'b1;
					first_d = 1'b1;
					state_d = ST_RD;
				end else begin
					i_d = '0;
					j_d = '0;
					cmd.acc_clear = 1'b1;
					cmd.rd_addr = '0;
					state_d = ST_LEN_RD;
				end
			end
			ST_RD: begin
				cmd.load_a = first_q;
				cmd.rd_addr = j_q[IdxW-1:0];
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				cmd.load_b = 1'b1;
				cmd.start_dist = 1'b1;
				state_d = ST_DIST;
			end
			ST_DIST: begin
				if (sts.dist_done) begin
					if (first_q) begin
						cmd.set_best = 1'b1;
						state_d = ST_STEP;
					end else if (sts.closer) begin
						cmd.set_best = 1'b1;
						cmd.rd_addr = IdxW'(i_q + 1'b1);
						state_d = ST_WR_J;
					end else begin
						state_d = ST_STEP;
					end
				end
			end
			ST_WR_J: begin
				// old city at i+1 moves to j
				cmd.wr_en = 1'b1;
				cmd.wr_addr = j_q[IdxW-1:0];
				state_d = ST_WR_I;
			end
			ST_WR_I: begin
				// city j moves to i+1
				cmd.wr_en = 1'b1;
				cmd.wr_addr = IdxW'(i_q + 1'b1);
				cmd.hold_b = 1'b1;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				state_d = ST_RD;
				first_d = 1'b0;
				j_d = j_q + 1'b1;
				if (j_q + 1'b1 >= n_q) begin
					i_d = i_q + 1'b1;
					state_d = ST_ROW;
				end
			end
			ST_LEN_RD: begin
				cmd.load_a = 1'b1;
				cmd.rd_addr = (j_q + 1'b1 < n_q) ? IdxW'(j_q + 1'b1) : '0;
				state_d = ST_LEN_WAIT;
			end
			ST_LEN_WAIT: begin
				cmd.load_b = 1'b1;
				cmd.start_dist = 1'b1;
				state_d = ST_LEN_DIST;
			end
			ST_LEN_DIST: begin
				cmd.acc_add = 1'b1;
				if (sts.dist_done) begin
					j_d = j_q + 1'b1;
					if (j_q + 1'b1 < n_q) begin
						cmd.rd_addr = IdxW'(j_q + 1'b1);
						state_d = ST_LEN_RD;
					end else begin
						i_d = '0;
						state_d = ST_OUT_RD;
					end
				end
			end
			ST_OUT_RD: begin
				cmd.rd_addr = i_q[IdxW-1:0];
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				m_capture = 1'b1;
				v_d = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready) begin
					v_d = 1'b0;
					if (i_q == n_q - 1'b1) begin
						n_d = '0; ovf_d = 1'b0; state_d = ST_LOAD;
					end else begin
						i_d = i_q + 1'b1;
						state_d = ST_OUT_RD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end
endmodule

>>> hw/rtl/nearest_neighbour_tour.sv
// top level of the nearest-neighbor tour block
`timescale 1ns / 1ps
// Cities load at one request per cycle until one flagged final; the block then
// builds the greedy tour in its city memory. The search visits n*(n-1)/2 pairs,
// each with a read of city j, the square and a 16-step root, plus swap writes
// of both cities when a later pair is closer, and a row state per row; the length
// pass measures each edge of the closed tour, and each output request is read,
// registered and held until the receiver takes it. Input is stalled throughout.
module nearest_neighbour_tour (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // city_id, pos_x, pos_y, pad
	input  logic        s_tlast,  // final_city
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // tour_id, tour_length, pad
	output logic        m_tlast,  // end_of_tour
	output logic        m_tuser   // overflowed
);
	import nnt_pkg::*;
	nnt_cmd_t cmd;
	nnt_sts_t sts;
	logic [15:0] out_id;
	logic [LenW-1:0] length;
	logic m_capture;
	logic [CityW-1:0] in_city;

	assign in_city = {s_tdata[31 +: CoordBits], s_tdata[16 +: CoordBits], s_tdata[15:0]};

	nnt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_final(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_last(m_tlast), .m_ovf(m_tuser), .m_capture(m_capture), .cmd(cmd), .sts(sts)
	);

	nnt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_city(in_city), .sts(sts),
		.out_id(out_id), .length(length)
	);

	always_ff @(posedge clk) begin
		if (m_capture) m_tdata <= {2'b00, length, out_id};
	end

	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !m_tvalid)
		else $error("input taken while a result is pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");
endmodule
